FILE: hw/rtl/avpm_pkg.sv
`default_nettype none
package avpm_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH  = 16;
  localparam int ORIGIN_COUNT = 2;
  localparam int NUM_Q        = ORIGIN_COUNT * 2;
  localparam int Q_W          = $clog2(NUM_Q);
  localparam int IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH    = NUM_Q * (2 ** IDX_W);
  localparam int RAM_AW       = Q_W + IDX_W;

  // field widths
  localparam int TIME_W  = 64;
  localparam int SEQ_W   = 32;
  localparam int FRAME_W = 16;
  localparam int CFG_W   = 32;
  localparam int PADDR_W = 4;

  // register map
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;
  localparam logic [1:0] REG_EXPIRE   = 2'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 32'd100000000;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 32'd200000000;
  localparam logic [CFG_W-1:0] EXPIRE_RST   = 32'd2000000000;

  // event kinds and origins
  localparam logic KIND_AUDIO = 1'b1;
  localparam logic ORIGIN_OBS = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  time_ns;
    logic [SEQ_W-1:0]   seq;
    logic [FRAME_W-1:0] frame;
  } q_entry_t;

  localparam int ENTRY_W = $bits(q_entry_t);

  typedef struct packed {
    logic             enable;
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] window;
    logic [CFG_W-1:0] expire;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  video_time;
    logic [TIME_W-1:0]  audio_time;
    logic [SEQ_W-1:0]   video_sn;
    logic [SEQ_W-1:0]   audio_sn;
    logic [FRAME_W-1:0] frame;
  } rec_t;

  typedef struct packed {
    logic               accepted;
    logic               matched;
    logic [TIME_W-1:0]  pair_video_time;
    logic [TIME_W-1:0]  pair_audio_time;
    logic [SEQ_W-1:0]   pair_video_seq;
    logic [SEQ_W-1:0]   pair_audio_seq;
    logic [FRAME_W-1:0] pair_frame;
    logic               network_match_valid;
    logic               network_related;
    logic [TIME_W-1:0]  network_video_time;
    logic [TIME_W-1:0]  network_audio_time;
  } res_t;

  typedef enum logic [1:0] {
    SCAN_SEARCH,
    SCAN_PRUNE_OPP,
    SCAN_PRUNE_OWN
  } scan_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_PRUNE_OPP,
    ST_PRUNE_OWN,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic       load;
    logic       admit;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       commit_fill;
    logic       append;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic scan_busy;
    logic res_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/avpm_ev_if.sv
`default_nettype none
interface avpm_ev_if;
  import avpm_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic               origin;
  logic [FRAME_W-1:0] frame_number;
  logic [TIME_W-1:0]  timestamp;

  modport source (output valid, action, origin, frame_number, timestamp, input ready);
  modport sink (input valid, action, origin, frame_number, timestamp, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/avpm_res_if.sv
`default_nettype none
interface avpm_res_if;
  import avpm_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic               matched;
  logic [TIME_W-1:0]  pair_video_time;
  logic [TIME_W-1:0]  pair_audio_time;
  logic [SEQ_W-1:0]   pair_video_seq;
  logic [SEQ_W-1:0]   pair_audio_seq;
  logic [FRAME_W-1:0] pair_frame;
  logic               network_match_valid;
  logic               network_related;
  logic [TIME_W-1:0]  network_video_time;
  logic [TIME_W-1:0]  network_audio_time;

  modport source (
    output valid, accepted, matched, pair_video_time, pair_audio_time, pair_video_seq,
           pair_audio_seq, pair_frame, network_match_valid, network_related,
           network_video_time, network_audio_time,
    input ready
  );
  modport sink (
    input valid, accepted, matched, pair_video_time, pair_audio_time, pair_video_seq,
          pair_audio_seq, pair_frame, network_match_valid, network_related,
          network_video_time, network_audio_time,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/avpm_ram.sv
`default_nettype none
module avpm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [D];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/avpm_ctrl.sv
`default_nettype none
module avpm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           ev_valid,
  output logic           ev_ready,
  input  avpm_pkg::stat_t stat,
  output avpm_pkg::cmd_t  cmd
);
  import avpm_pkg::*;

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.scan_mode = SCAN_SEARCH;
    ev_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        ev_ready = 1'b1;
        if (ev_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.accept) begin
          cmd.admit      = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_SEARCH;
          state_next     = ST_SEARCH;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (!stat.scan_busy) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_PRUNE_OPP;
          state_next     = ST_PRUNE_OPP;
        end
      end
      ST_PRUNE_OPP: begin
        if (!stat.scan_busy) begin
          cmd.commit_fill = 1'b1;
          cmd.scan_start  = 1'b1;
          cmd.scan_mode   = SCAN_PRUNE_OWN;
          state_next      = ST_PRUNE_OWN;
        end
      end
      ST_PRUNE_OWN: begin
        if (!stat.scan_busy) begin
          cmd.append = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.res_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/avpm_dp.sv
`default_nettype none
module avpm_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  avpm_pkg::cfg_t               cfg,
  input  logic                         ev_action,
  input  logic                         ev_origin,
  input  logic [avpm_pkg::FRAME_W-1:0] ev_frame,
  input  logic [avpm_pkg::TIME_W-1:0]  ev_time,
  input  avpm_pkg::cmd_t               cmd,
  output avpm_pkg::stat_t              stat,
  output avpm_pkg::res_t               res,
  output logic                         res_valid,
  input  logic                         res_ready
);
  import avpm_pkg::*;

  // current event
  logic               a_r;
  logic               o_r;
  logic [FRAME_W-1:0] fr_r;
  logic [TIME_W-1:0]  ts_r;
  logic [SEQ_W-1:0]   seq_r;
  logic               acc_r;

  // per-queue state
  logic [TIME_W-1:0] last_t [NUM_Q];
  logic [SEQ_W-1:0]  ctr    [NUM_Q];
  logic [CNT_W-1:0]  fill   [NUM_Q];

  // last match per origin
  rec_t rec       [ORIGIN_COUNT];
  logic rec_valid [ORIGIN_COUNT];

  // scan engine
  scan_mode_t        mode_r;
  logic              scan_on;
  logic [CNT_W-1:0]  scan_cnt;
  logic [CNT_W-1:0]  scan_lim;
  logic [CNT_W-1:0]  wr_ptr;
  logic              s1_valid;
  logic [CNT_W-1:0]  s1_idx;
  logic              s2_valid;
  logic [TIME_W-1:0] s2_d;
  logic [CNT_W-1:0]  s2_idx;
  q_entry_t          s2_ent;
  logic              found;
  logic [TIME_W-1:0] best_d;
  logic [CNT_W-1:0]  best_idx;
  q_entry_t          best_ent;

  logic [Q_W-1:0]    own_q;
  logic [Q_W-1:0]    opp_q;
  logic [Q_W-1:0]    scan_q;
  logic [Q_W-1:0]    start_q;
  logic [CNT_W-1:0]  start_idx;
  logic              issue;
  logic [TIME_W-1:0] last_sel;
  logic [TIME_W-1:0] gap;
  logic              bounce;
  logic [SEQ_W-1:0]  seq_inc;

  logic [ENTRY_W-1:0] rd_bits;
  q_entry_t           rd;
  logic               we;
  logic [RAM_AW-1:0]  waddr;
  q_entry_t           wentry;

  logic              dpos_b;
  logic [TIME_W-1:0] dpos;
  logic [TIME_W-1:0] dneg;
  logic [TIME_W-1:0] s1_d;
  logic              age_b;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic              skip;
  logic              keep;
  logic              in_win;
  logic              better;

  rec_t pair;
  logic net_ok;

  assign own_q   = {o_r, a_r};
  assign opp_q   = {o_r, ~a_r};
  assign scan_q  = (mode_r == SCAN_PRUNE_OWN) ? own_q : opp_q;
  assign start_q = (cmd.scan_mode == SCAN_PRUNE_OWN) ? own_q : opp_q;

  // debounce against the last accepted event of this kind and origin
  assign last_sel    = last_t[own_q];
  assign gap         = ts_r - last_sel;
  assign bounce      = (last_sel != '0) && (gap < {{(TIME_W-CFG_W){1'b0}}, cfg.debounce});
  assign seq_inc     = ctr[own_q] + SEQ_W'(1);
  assign stat.accept = cfg.enable && !bounce;

  // a full own queue drops its oldest entry, so the prune starts past it
  assign start_idx = ((cmd.scan_mode == SCAN_PRUNE_OWN) && (fill[own_q] == CNT_W'(QUEUE_DEPTH)))
                     ? CNT_W'(1) : '0;
  assign issue     = scan_on && (scan_cnt < scan_lim);
  assign stat.scan_busy = scan_on || s1_valid || s2_valid;

  assign rd = q_entry_t'(rd_bits);

  // distance to the new event for the search
  assign {dpos_b, dpos} = {1'b0, rd.time_ns} - {1'b0, ts_r};
  assign dneg           = ts_r - rd.time_ns;
  assign s1_d           = dpos_b ? dneg : dpos;

  // age of the entry for the prune
  assign {age_b, age} = {1'b0, ts_r} - {1'b0, rd.time_ns};
  assign expired      = !age_b && (age > {{(TIME_W-CFG_W){1'b0}}, cfg.expire});
  assign skip         = (mode_r == SCAN_PRUNE_OPP) && found && (s1_idx == best_idx);
  assign keep         = s1_valid && (mode_r != SCAN_SEARCH) && !expired && !skip;

  // best candidate update
  assign in_win = s2_d <= {{(TIME_W-CFG_W){1'b0}}, cfg.window};
  assign better = !found || (s2_d < best_d);

  // ram write: compaction beat or append of the new event
  assign we    = keep || (cmd.append && !found);
  assign waddr = {scan_q, wr_ptr[IDX_W-1:0]};
  always_comb begin
    if (keep) begin
      wentry = rd;
    end else begin
      wentry.time_ns = ts_r;
      wentry.seq     = seq_r;
      wentry.frame   = (a_r == KIND_AUDIO) ? '0 : fr_r;
    end
  end

  avpm_ram #(
    .W (ENTRY_W),
    .D (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr ({scan_q, scan_cnt[IDX_W-1:0]}),
    .rdata (rd_bits)
  );

  // the new pair
  always_comb begin
    if (a_r == KIND_AUDIO) begin
      pair.video_time = best_ent.time_ns;
      pair.video_sn   = best_ent.seq;
      pair.frame      = best_ent.frame;
      pair.audio_time = ts_r;
      pair.audio_sn   = seq_r;
    end else begin
      pair.video_time = ts_r;
      pair.video_sn   = seq_r;
      pair.frame      = fr_r;
      pair.audio_time = best_ent.time_ns;
      pair.audio_sn   = best_ent.seq;
    end
  end

  assign net_ok        = found && (o_r == ORIGIN_OBS) && rec_valid[0];
  assign stat.res_free = !res_valid || res_ready;

  // event capture and per-queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_r <= 1'b0;
      for (int q = 0; q < NUM_Q; q++) begin
        last_t[q] <= '0;
        ctr[q]    <= '0;
        fill[q]   <= '0;
      end
    end else begin
      if (cmd.load) begin
        a_r   <= ev_action;
        o_r   <= ev_origin;
        fr_r  <= ev_frame;
        ts_r  <= ev_time;
        acc_r <= 1'b0;
      end
      if (cmd.admit) begin
        acc_r         <= 1'b1;
        last_t[own_q] <= ts_r;
        ctr[own_q]    <= seq_inc;
        seq_r         <= seq_inc;
      end
      if (cmd.commit_fill) begin
        fill[opp_q] <= wr_ptr;
      end
      if (cmd.append) begin
        fill[own_q] <= wr_ptr + CNT_W'(!found);
      end
    end
  end

  // scan engine: read pointer, search stages, compaction pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        mode_r   <= cmd.scan_mode;
        scan_on  <= 1'b1;
        scan_cnt <= start_idx;
        scan_lim <= fill[start_q];
        wr_ptr   <= '0;
      end else if (issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end else begin
        scan_on <= 1'b0;
      end
      if (keep) begin
        wr_ptr <= wr_ptr + CNT_W'(1);
      end
      s1_valid <= issue;
      s1_idx   <= scan_cnt;
      s2_valid <= s1_valid && (mode_r == SCAN_SEARCH);
      s2_d     <= s1_d;
      s2_idx   <= s1_idx;
      s2_ent   <= rd;
      if (cmd.load) begin
        found <= 1'b0;
      end else if (s2_valid && in_win && better) begin
        found    <= 1'b1;
        best_d   <= s2_d;
        best_idx <= s2_idx;
        best_ent <= s2_ent;
      end
    end
  end

  // result register and last-match records
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      for (int k = 0; k < ORIGIN_COUNT; k++) begin
        rec_valid[k] <= 1'b0;
      end
    end else begin
      if (cmd.publish) begin
        res_valid <= 1'b1;
        if (found) begin
          rec[o_r]       <= pair;
          rec_valid[o_r] <= 1'b1;
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res.accepted            <= acc_r;
      res.matched             <= found;
      res.pair_video_time     <= found ? pair.video_time : '0;
      res.pair_audio_time     <= found ? pair.audio_time : '0;
      res.pair_video_seq      <= found ? pair.video_sn : '0;
      res.pair_audio_seq      <= found ? pair.audio_sn : '0;
      res.pair_frame          <= found ? pair.frame : '0;
      res.network_match_valid <= net_ok;
      res.network_related     <= net_ok && (rec[0].frame == pair.frame);
      res.network_video_time  <= net_ok ? rec[0].video_time : '0;
      res.network_audio_time  <= net_ok ? rec[0].audio_time : '0;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/av_pop_event_pair_matcher_top.sv
`default_nettype none
// channel | dir | payload
// ev      | in  | action, origin, frame_number, timestamp
// res     | out | accepted, matched, pair_*, network_*
// apb     | in  | enable, debounce_ns, match_window_ns, expire_ns at 0x0..0xc
//
// an accepted event takes one search pass over the opposite queue and two compaction
// passes, over the opposite and then the own queue, through the single read port of the
// queue ram, one entry per cycle; a dropped event skips all three passes.
// synchronous reset clears fills, counters, debounce times and match records.
// a finished result waits in the output register; a new event is taken meanwhile.
module av_pop_event_pair_matcher_top (
  input  logic                         clk,
  input  logic                         rst,
  avpm_ev_if.sink                      ev,
  avpm_res_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [avpm_pkg::PADDR_W-1:0] paddr,
  input  logic [avpm_pkg::CFG_W-1:0]   pwdata,
  output logic [avpm_pkg::CFG_W-1:0]   prdata,
  output logic                         pready
);
  import avpm_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  res_t  res_r;
  logic  cfg_we;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable   <= 1'b1;
      cfg.debounce <= DEBOUNCE_RST;
      cfg.window   <= WINDOW_RST;
      cfg.expire   <= EXPIRE_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_ENABLE:   cfg.enable   <= pwdata[0];
        REG_DEBOUNCE: cfg.debounce <= pwdata;
        REG_WINDOW:   cfg.window   <= pwdata;
        REG_EXPIRE:   cfg.expire   <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:   prdata = {{(CFG_W-1){1'b0}}, cfg.enable};
      REG_DEBOUNCE: prdata = cfg.debounce;
      REG_WINDOW:   prdata = cfg.window;
      REG_EXPIRE:   prdata = cfg.expire;
      default:      prdata = '0;
    endcase
  end

  avpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev.valid),
    .ev_ready (ev.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  avpm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ev_action (ev.action),
    .ev_origin (ev.origin),
    .ev_frame  (ev.frame_number),
    .ev_time   (ev.timestamp),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res_r),
    .res_valid (res.valid),
    .res_ready (res.ready)
  );

  // result beat
  assign res.accepted            = res_r.accepted;
  assign res.matched             = res_r.matched;
  assign res.pair_video_time     = res_r.pair_video_time;
  assign res.pair_audio_time     = res_r.pair_audio_time;
  assign res.pair_video_seq      = res_r.pair_video_seq;
  assign res.pair_audio_seq      = res_r.pair_audio_seq;
  assign res.pair_frame          = res_r.pair_frame;
  assign res.network_match_valid = res_r.network_match_valid;
  assign res.network_related     = res_r.network_related;
  assign res.network_video_time  = res_r.network_video_time;
  assign res.network_audio_time  = res_r.network_audio_time;
endmodule
`default_nettype wire
